// ===== rtl/compacting_slot_store_unit_assert.svh =====
// ----------------------------------------------------------------------------
// compacting_slot_store_unit assertion macros
// Clocked assertion wrappers; they compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_SLOT_STORE_UNIT_ASSERT_SVH
`define COMPACTING_SLOT_STORE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define CSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CSS_ASSERT(label, prop, msg)
`define CSS_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/css_pkg.sv =====
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the compacting slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam logic [3:0] MOVE_LIMIT = 4'd15;

    localparam logic [1:0] CMD_SAVE  = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] REG_REGION_BASE = 2'd0;
    localparam logic [1:0] REG_REGION_END  = 2'd1;
    localparam logic [1:0] REG_MAX_ENTRY   = 2'd2;

    localparam logic [15:0] RST_REGION_BASE = 16'd232;
    localparam logic [15:0] RST_REGION_END  = 16'd16384;
    localparam logic [15:0] RST_MAX_ENTRY   = 16'd8192;

    localparam logic REC_MOVE  = 1'b0;
    localparam logic REC_FINAL = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [15:0] length;
    } t_cmd_item;

    typedef struct packed {
        logic        record_kind;
        logic        success;
        logic [3:0]  entry_index;
        logic [15:0] move_from;
        logic [15:0] move_to;
        logic [15:0] move_bytes;
        logic [15:0] entry_offset;
        logic [15:0] entry_size;
        logic [15:0] free_bytes;
        logic        last_record;
    } t_rec_item;

    typedef struct packed {
        logic [15:0] region_base;
        logic [15:0] region_end;
        logic [15:0] max_entry_bytes;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic comp_init;
        logic scan_start;
        logic advance;
        logic move;
        logic place;
        logic final_read;
        logic load_final;
    } t_dp_cmd;

    typedef struct packed {
        logic need_compact;
        logic scan_done;
        logic found;
        logic at_write;
        logic at_limit;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/css_stream_if.sv =====
// ----------------------------------------------------------------------------
// css_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface css_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/css_datapath.sv =====
// ----------------------------------------------------------------------------
// css_datapath
// Slot table memory, scan unit, compaction pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compacting_slot_store_unit_assert.svh"

module css_datapath #(
    parameter int SLOT_COUNT = css_pkg::SLOT_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire css_pkg::t_cfg     i_cfg,
    input  wire css_pkg::t_cmd_item i_item,
    input  wire css_pkg::t_dp_cmd  i_cmd,
    output css_pkg::t_dp_sts       o_sts,
    output logic                   o_rec_valid,
    output css_pkg::t_rec_item     o_rec_item,
    input  wire logic              i_rec_ready
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    // entry word: offset in [31:16], size in [15:0]
    logic [31:0]           r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] r_done;

    css_pkg::t_cmd_item r_item;
    css_pkg::t_rec_item r_out;
    logic               r_out_valid;
    logic               r_need;
    logic               r_ok;
    logic [15:0]        r_wr;
    logic [3:0]         r_moves;
    logic               r_scan_on;
    logic [IW-1:0]      r_scan_cnt;
    logic               r_rd_scan;
    logic [IW-1:0]      r_rd_addr;
    logic [31:0]        r_rd_data;
    logic               r_found;
    logic [IW-1:0]      r_pick_idx;
    logic [15:0]        r_pick_off;
    logic [15:0]        r_pick_size;
    logic [16:0]        r_top;
    logic [15:0]        r_free;

    logic          slot_ok;
    logic [IW-1:0] slot_idx;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          e_occ;
    logic [15:0]   e_off;
    logic [15:0]   e_size;
    logic [16:0]   e_end;
    logic [16:0]   free17;
    logic          fits;
    logic          f_occ;
    logic [15:0]   f_off;
    logic [15:0]   f_size;
    logic          f_ok;

    assign slot_ok  = 32'(r_item.slot) < SLOT_COUNT;
    assign slot_idx = IW'(r_item.slot);

    assign rd_en   = r_scan_on || i_cmd.final_read;
    assign rd_addr = r_scan_on ? r_scan_cnt : slot_idx;

    assign e_occ  = r_valid[r_rd_addr];
    assign e_off  = r_rd_data[31:16];
    assign e_size = r_rd_data[15:0];
    assign e_end  = {1'b0, e_off} + {1'b0, e_size};

    assign free17 = ({1'b0, i_cfg.region_end} > r_top) ? ({1'b0, i_cfg.region_end} - r_top)
                                                         : 17'd0;
    assign fits   = r_need && (r_item.command == css_pkg::CMD_SAVE)
                    && ({1'b0, r_item.length} <= free17);

    assign wr_en   = i_cmd.move || (i_cmd.place && fits);
    assign wr_addr = i_cmd.move ? r_pick_idx : slot_idx;
    assign wr_data = i_cmd.move ? {r_wr, r_pick_size} : {r_top[15:0], r_item.length};

    assign f_occ  = slot_ok && r_valid[slot_idx];
    assign f_off  = f_occ ? r_rd_data[31:16] : 16'd0;
    assign f_size = f_occ ? r_rd_data[15:0] : 16'd0;
    assign f_ok   = (r_item.command == css_pkg::CMD_QUERY)
                    ? (f_occ && (f_size <= i_cfg.max_entry_bytes)) : r_ok;

    always_comb begin
        o_sts.need_compact = slot_ok && (((r_item.command == css_pkg::CMD_SAVE)
                                          && (r_item.length != 16'd0))
                                         || (r_item.command == css_pkg::CMD_ERASE));
        o_sts.scan_done    = r_rd_scan && (r_rd_addr == LAST_IDX);
        o_sts.found        = r_found;
        o_sts.at_write     = (r_pick_off == r_wr);
        o_sts.at_limit     = (r_moves == css_pkg::MOVE_LIMIT);
        o_sts.out_busy     = r_out_valid;
    end

    assign o_rec_valid = r_out_valid;
    assign o_rec_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_scan_on   <= 1'b0;
            r_rd_scan   <= 1'b0;
        end else begin
            r_rd_scan <= r_scan_on;
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
            end else if (r_scan_on && (r_scan_cnt == LAST_IDX)) begin
                r_scan_on <= 1'b0;
            end
            if (i_cmd.comp_init) begin
                r_valid[slot_idx] <= 1'b0;
            end else if (i_cmd.place && fits) begin
                r_valid[slot_idx] <= 1'b1;
            end
            if (i_cmd.move || i_cmd.load_final) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_rec_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
            r_need <= 1'b0;
            r_ok   <= 1'b0;
        end
        if (i_cmd.comp_init) begin
            r_need  <= 1'b1;
            r_ok    <= (r_item.command == css_pkg::CMD_ERASE);
            r_done  <= '0;
            r_wr    <= i_cfg.region_base;
            r_moves <= 4'd0;
        end
        if (i_cmd.scan_start) begin
            r_scan_cnt <= '0;
            r_found    <= 1'b0;
            r_top      <= {1'b0, i_cfg.region_base};
        end else if (r_scan_on) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (r_rd_scan) begin
            if (e_occ && !r_done[r_rd_addr] && (!r_found || (e_off < r_pick_off))) begin
                r_found     <= 1'b1;
                r_pick_idx  <= r_rd_addr;
                r_pick_off  <= e_off;
                r_pick_size <= e_size;
            end
            if (e_occ && (e_end > r_top)) begin
                r_top <= e_end;
            end
        end
        if (i_cmd.advance || i_cmd.move) begin
            r_done[r_pick_idx] <= 1'b1;
            r_wr               <= r_wr + r_pick_size;
        end
        if (i_cmd.move) begin
            r_moves <= r_moves + 4'd1;
            r_out   <= '{record_kind:  css_pkg::REC_MOVE,
                         success:      1'b0,
                         entry_index:  4'(r_pick_idx),
                         move_from:    r_pick_off,
                         move_to:      r_wr,
                         move_bytes:   r_pick_size,
                         entry_offset: 16'd0,
                         entry_size:   16'd0,
                         free_bytes:   16'd0,
                         last_record:  1'b0};
        end
        if (i_cmd.place) begin
            r_free <= fits ? (free17[15:0] - r_item.length) : free17[15:0];
            if (fits) begin
                r_ok <= 1'b1;
            end
        end
        if (i_cmd.load_final) begin
            r_out <= '{record_kind:  css_pkg::REC_FINAL,
                       success:      f_ok,
                       entry_index:  r_item.slot,
                       move_from:    16'd0,
                       move_to:      16'd0,
                       move_bytes:   16'd0,
                       entry_offset: f_off,
                       entry_size:   f_size,
                       free_bytes:   r_free,
                       last_record:  1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (r_scan_on) begin
            r_rd_addr <= r_scan_cnt;
        end
    end

    `CSS_ASSERT(a_load_into_empty, (i_cmd.move || i_cmd.load_final) |-> !r_out_valid, "result register overwritten")
    `CSS_ASSERT(a_move_limit, i_cmd.move |-> (r_moves != css_pkg::MOVE_LIMIT), "move limit exceeded")
    `CSS_ASSERT(a_scan_restart, i_cmd.scan_start |-> (!r_scan_on && !r_rd_scan), "scan restarted while busy")
    `CSS_ASSERT_RST(a_reset_out, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

`default_nettype wire

// ===== rtl/css_ctrl.sv =====
// ----------------------------------------------------------------------------
// css_ctrl
// Command sequencer: compaction passes, top scan, placement, final beat.
// ----------------------------------------------------------------------------
`default_nettype none

module css_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire css_pkg::t_dp_sts i_sts,
    output css_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_PICK   = 9'b000001000,
        S_MOVE   = 9'b000010000,
        S_TOP    = 9'b000100000,
        S_PLACE  = 9'b001000000,
        S_FINRD  = 9'b010000000,
        S_FINAL  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.scan_start = 1'b1;
                if (i_sts.need_compact) begin
                    o_cmd.comp_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!i_sts.found || (!i_sts.at_write && i_sts.at_limit)) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_TOP;
                end else if (i_sts.at_write) begin
                    o_cmd.advance    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.move       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_TOP: begin
                if (i_sts.scan_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_FINRD;
            end
            S_FINRD: begin
                o_cmd.final_read = 1'b1;
                n_state          = S_FINAL;
            end
            S_FINAL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/compacting_slot_store_unit.sv =====
// ----------------------------------------------------------------------------
// compacting_slot_store_unit
// Slot table over a byte region with offset-ordered compaction and copy beats.
// ----------------------------------------------------------------------------
// A command without compaction runs one scan of the slot table, places, then sends its final beat.
// Each compaction pass is one scan of the slot table, then at most one move beat, which
// waits while the result register is full; a last scan then finds the top of the entries.
// One command at a time, paced by the single table read port.
// Reset: all slots free, config registers to their defaults; no clearing pass.
`default_nettype none

module compacting_slot_store_unit #(
    parameter int SLOT_COUNT = css_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    css_stream_if.sink       i_cmd,
    css_stream_if.source     o_rec
);

    css_pkg::t_cfg      r_cfg;
    css_pkg::t_dp_cmd   dp_cmd;
    css_pkg::t_dp_sts   dp_sts;
    css_pkg::t_rec_item rec_item;
    logic               rec_valid;
    logic               in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_base     <= css_pkg::RST_REGION_BASE;
            r_cfg.region_end      <= css_pkg::RST_REGION_END;
            r_cfg.max_entry_bytes <= css_pkg::RST_MAX_ENTRY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                css_pkg::REG_REGION_BASE: r_cfg.region_base     <= i_cfg_data;
                css_pkg::REG_REGION_END:  r_cfg.region_end      <= i_cfg_data;
                css_pkg::REG_MAX_ENTRY:   r_cfg.max_entry_bytes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    css_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    css_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (i_cmd.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_rec_valid (rec_valid),
        .o_rec_item  (rec_item),
        .i_rec_ready (o_rec.ready)
    );

    assign i_cmd.ready = in_ready;
    assign o_rec.valid = rec_valid;
    assign o_rec.data  = rec_item;

endmodule

`default_nettype wire

// ===== dv/compacting_slot_store_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compacting_slot_store_unit_test
// Drives save, erase, query and unused commands into the slot store and checks
// every move beat and final status beat against a cycle-free table model.
// The region registers are swept between phases, including wrapping and empty
// regions. Random gaps and stalls are applied on both channels. One long
// output hold-off backs the block up.
// ----------------------------------------------------------------------------

module compacting_slot_store_unit_test;

    localparam int SLOT_COUNT = css_pkg::SLOT_COUNT_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    css_stream_if #(.T(css_pkg::t_cmd_item)) cmd_chan ();
    css_stream_if #(.T(css_pkg::t_rec_item)) rec_chan ();

    compacting_slot_store_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_chan),
        .o_rec      (rec_chan)
    );

    always #1 i_clk = ~i_clk;

    // table model
    logic [15:0] slot_off [SLOT_COUNT];
    logic [15:0] slot_len [SLOT_COUNT];
    logic [15:0] cfg_base;
    logic [15:0] cfg_end;
    logic [15:0] cfg_max_len;

    css_pkg::t_rec_item pending_records [$];
    int                 error_count = 0;
    bit                 sender_gaps = 1'b1;
    bit                 receiver_stalls = 1'b1;
    int                 hold_cycles = 0;

    function automatic int unsigned table_top();
        int unsigned top;
        int unsigned tail;
        int i;
        top = 32'(cfg_base);
        for (i = 0; i < SLOT_COUNT; i++) begin
            tail = 32'(slot_off[i]) + 32'(slot_len[i]);
            if (slot_len[i] != 0 && tail > top)
                top = tail;
        end
        return top;
    endfunction

    function automatic int unsigned bytes_free();
        int unsigned top;
        top = table_top();
        return (32'(cfg_end) > top) ? 32'(cfg_end) - top : 0;
    endfunction

    // entries packed down from the base in offset order, one move beat per shift
    function automatic void compact_table();
        bit                 placed [SLOT_COUNT];
        int unsigned        wr;
        int                 moves;
        int                 pick;
        int                 i;
        int                 pass;
        css_pkg::t_rec_item mv;
        wr = 32'(cfg_base);
        moves = 0;
        for (i = 0; i < SLOT_COUNT; i++)
            placed[i] = 1'b0;
        for (pass = 0; pass < SLOT_COUNT; pass++) begin
            pick = -1;
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (!placed[i] && slot_len[i] != 0 &&
                        (pick < 0 || slot_off[i] < slot_off[pick]))
                    pick = i;
            end
            if (pick < 0)
                break;
            placed[pick] = 1'b1;
            if (slot_off[pick] != wr[15:0]) begin
                if (moves >= int'(css_pkg::MOVE_LIMIT))
                    break;
                mv = '0;
                mv.record_kind = css_pkg::REC_MOVE;
                mv.entry_index = pick[3:0];
                mv.move_from   = slot_off[pick];
                mv.move_to     = wr[15:0];
                mv.move_bytes  = slot_len[pick];
                pending_records.push_back(mv);
                slot_off[pick] = wr[15:0];
                moves++;
            end
            wr = (wr + 32'(slot_len[pick])) & 32'hFFFF;
        end
    endfunction

    function automatic void predict_command(input css_pkg::t_cmd_item c);
        bit                 in_range;
        logic               ok;
        css_pkg::t_rec_item fin;
        in_range = int'(c.slot) < SLOT_COUNT;
        ok = 1'b0;
        case (c.command)
            css_pkg::CMD_SAVE: begin
                if (in_range && c.length != 0) begin
                    slot_len[c.slot] = '0;
                    slot_off[c.slot] = '0;
                    compact_table();
                    if (32'(c.length) <= bytes_free()) begin
                        slot_off[c.slot] = 16'(table_top());
                        slot_len[c.slot] = c.length;
                        ok = 1'b1;
                    end
                end
            end
            css_pkg::CMD_ERASE: begin
                if (in_range) begin
                    slot_len[c.slot] = '0;
                    slot_off[c.slot] = '0;
                    compact_table();
                    ok = 1'b1;
                end
            end
            css_pkg::CMD_QUERY: begin
                ok = in_range && slot_len[c.slot] != 0 && slot_len[c.slot] <= cfg_max_len;
            end
            default: ;
        endcase
        fin = '0;
        fin.record_kind = css_pkg::REC_FINAL;
        fin.success     = ok;
        fin.entry_index = c.slot;
        if (in_range && slot_len[c.slot] != 0) begin
            fin.entry_offset = slot_off[c.slot];
            fin.entry_size   = slot_len[c.slot];
        end
        fin.free_bytes  = 16'(bytes_free());
        fin.last_record = 1'b1;
        pending_records.push_back(fin);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_record(input css_pkg::t_rec_item got);
        css_pkg::t_rec_item want;
        if (pending_records.size() == 0) begin
            $error("record beat with nothing pending: kind %0d slot %0d",
                   got.record_kind, got.entry_index);
            error_count++;
            return;
        end
        want = pending_records.pop_front();
        check_field("record_kind",  16'(want.record_kind),  16'(got.record_kind));
        check_field("success",      16'(want.success),      16'(got.success));
        check_field("entry_index",  16'(want.entry_index),  16'(got.entry_index));
        check_field("move_from",    want.move_from,    got.move_from);
        check_field("move_to",      want.move_to,      got.move_to);
        check_field("move_bytes",   want.move_bytes,   got.move_bytes);
        check_field("entry_offset", want.entry_offset, got.entry_offset);
        check_field("entry_size",   want.entry_size,   got.entry_size);
        check_field("free_bytes",   want.free_bytes,   got.free_bytes);
        check_field("last_record",  16'(want.last_record),  16'(got.last_record));
    endfunction

    // record sink: checks each beat, then stalls ready per beat or for a hold-off
    initial begin : record_sink
        int stall_left;
        stall_left = 0;
        rec_chan.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rec_chan.valid && rec_chan.ready) begin
                check_record(rec_chan.data);
                stall_left = receiver_stalls ? $urandom_range(0, 12) : 0;
            end
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rec_chan.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rec_chan.ready <= 1'b0;
            end else begin
                rec_chan.ready <= 1'b1;
            end
        end
    end

    task automatic set_idling(input bit gaps, input bit stalls);
        sender_gaps = gaps;
        receiver_stalls = stalls;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            css_pkg::REG_REGION_BASE: cfg_base = val;
            css_pkg::REG_REGION_END:  cfg_end = val;
            css_pkg::REG_MAX_ENTRY:   cfg_max_len = val;
            default: ;
        endcase
    endtask

    task automatic write_region(input logic [15:0] base, input logic [15:0] lim,
                                input logic [15:0] max_len);
        write_reg(css_pkg::REG_REGION_BASE, base);
        write_reg(css_pkg::REG_REGION_END, lim);
        write_reg(css_pkg::REG_MAX_ENTRY, max_len);
    endtask

    // leaves valid high at return; the next send or wait_idle settles it at the next negedge
    task automatic send_command(input logic [1:0] op, input logic [3:0] slot,
                                input logic [15:0] len);
        css_pkg::t_cmd_item beat;
        int                 gap;
        beat.command = op;
        beat.slot    = slot;
        beat.length  = len;
        gap = sender_gaps ? $urandom_range(0, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_chan.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_chan.data  <= beat;
        cmd_chan.valid <= 1'b1;
        do @(posedge i_clk); while (!cmd_chan.ready);
        predict_command(beat);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        cmd_chan.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] draw_length(input int unsigned span);
        int unsigned cap;
        cap = (span / 6 > 1) ? span / 6 : 1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'($urandom);
            2, 3:    return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(1, cap));
        endcase
    endfunction

    task automatic send_random_command(input int unsigned span);
        int unsigned roll;
        logic [1:0]  op;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            op = css_pkg::CMD_SAVE;
        else if (roll < 72)
            op = css_pkg::CMD_ERASE;
        else if (roll < 94)
            op = css_pkg::CMD_QUERY;
        else
            op = CMD_UNUSED;
        send_command(op, 4'($urandom_range(0, SLOT_COUNT - 1)), draw_length(span));
    endtask

    task automatic test_directed_commands();
        send_command(css_pkg::CMD_QUERY, 4'd0,  16'd0);
        send_command(CMD_UNUSED,         4'd15, 16'hFFFF);
        send_command(css_pkg::CMD_SAVE,  4'd0,  16'd0);
        send_command(css_pkg::CMD_SAVE,  4'd0,  16'd100);
        send_command(css_pkg::CMD_SAVE,  4'd15, 16'd200);
        send_command(css_pkg::CMD_SAVE,  4'd7,  16'd300);
        send_command(css_pkg::CMD_SAVE,  4'd1,  16'hFFFF);
        send_command(css_pkg::CMD_QUERY, 4'd15, 16'd0);
        send_command(css_pkg::CMD_ERASE, 4'd0,  16'd0);
        send_command(css_pkg::CMD_SAVE,  4'd15, 16'd50);
        send_command(css_pkg::CMD_ERASE, 4'd9,  16'd0);
        // larger than max_entry_bytes: stored, but a query must refuse it
        send_command(css_pkg::CMD_SAVE,  4'd2,  16'd8193);
        send_command(css_pkg::CMD_QUERY, 4'd2,  16'd0);
        // exact fit, then nothing left
        send_command(css_pkg::CMD_SAVE,  4'd4,  16'd7609);
        send_command(css_pkg::CMD_SAVE,  4'd5,  16'd1);
        // resave that does not fit loses the old entry
        send_command(css_pkg::CMD_SAVE,  4'd2,  16'hFFFF);
        send_command(css_pkg::CMD_QUERY, 4'd2,  16'd0);
        send_command(css_pkg::CMD_ERASE, 4'd4,  16'd0);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(css_pkg::REG_MAX_ENTRY, 16'd0);
        send_command(css_pkg::CMD_QUERY, 4'd15, 16'd0);
        wait_idle();
        // base near the top: compaction pointer wraps
        write_region(16'hFFF0, 16'hFFFF, 16'hFFFF);
        send_command(css_pkg::CMD_ERASE, 4'd3, 16'd0);
        send_command(css_pkg::CMD_QUERY, 4'd7, 16'd0);
        wait_idle();
        // end below base: no room at all
        write_region(16'h1000, 16'h0800, 16'hFFFF);
        send_command(css_pkg::CMD_SAVE, 4'd8, 16'd1);
        wait_idle();
        write_region(16'h0000, 16'hFFFF, 16'hFFFF);
        send_command(css_pkg::CMD_SAVE,  4'd8, 16'h8000);
        send_command(css_pkg::CMD_ERASE, 4'd7, 16'd0);
        wait_idle();
    endtask

    // fill every slot, shift the base, then free one: a full set of move beats
    task automatic test_full_table_compaction();
        logic [3:0]  order [SLOT_COUNT];
        logic [3:0]  tmp;
        logic [15:0] base;
        int          i;
        int          j;
        int          round;
        for (round = 0; round < 3; round++) begin
            set_idling(round != 1, 1'b1);
            base = 16'($urandom_range(0, 2000));
            write_region(base, 16'hFFFF, 16'($urandom));
            for (i = 0; i < SLOT_COUNT; i++)
                order[i] = 4'(i);
            for (i = SLOT_COUNT - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < SLOT_COUNT; i++)
                send_command(css_pkg::CMD_SAVE, order[i], 16'($urandom_range(1, 2048)));
            wait_idle();
            write_reg(css_pkg::REG_REGION_BASE, base + 16'($urandom_range(1, 64)));
            send_command(css_pkg::CMD_ERASE, 4'($urandom_range(0, SLOT_COUNT - 1)),
                         16'($urandom));
            send_command(css_pkg::CMD_QUERY, 4'($urandom_range(0, SLOT_COUNT - 1)),
                         16'($urandom));
            send_command(css_pkg::CMD_SAVE, 4'($urandom_range(0, SLOT_COUNT - 1)),
                         16'($urandom_range(1, 2048)));
            wait_idle();
        end
    endtask

    // record channel held off while commands keep coming, so the input backs up
    task automatic test_output_hold_off();
        int i;
        write_region(css_pkg::RST_REGION_BASE, css_pkg::RST_REGION_END,
                     css_pkg::RST_MAX_ENTRY);
        set_idling(1'b0, 1'b0);
        @(posedge i_clk);
        hold_cycles = 1000;
        for (i = 0; i < 12; i++) begin
            if (i % 3 == 2)
                send_command(css_pkg::CMD_ERASE, 4'($urandom_range(0, SLOT_COUNT - 1)),
                             16'd0);
            else
                send_command(css_pkg::CMD_SAVE, 4'($urandom_range(0, SLOT_COUNT - 1)),
                             16'($urandom_range(1, 1500)));
        end
        wait_idle();
    endtask

    task automatic test_random_mix();
        logic [15:0] base;
        logic [15:0] lim;
        logic [15:0] max_len;
        int unsigned span;
        int          phase;
        int          n;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    base = css_pkg::RST_REGION_BASE;
                    lim = css_pkg::RST_REGION_END;
                    max_len = css_pkg::RST_MAX_ENTRY;
                end
                1: begin
                    base = 16'h0000;
                    lim = 16'hFFFF;
                    max_len = 16'hFFFF;
                end
                2: begin
                    base = 16'($urandom_range(0, 8192));
                    lim = base + 16'($urandom_range(512, 12000));
                    max_len = 16'($urandom_range(0, 4096));
                end
                3: begin
                    base = 16'($urandom_range(16'hF000, 16'hFFFF));
                    lim = 16'hFFFF;
                    max_len = 16'($urandom);
                end
                default: begin
                    base = 16'($urandom);
                    lim = 16'($urandom);
                    max_len = 16'($urandom);
                end
            endcase
            write_region(base, lim, max_len);
            set_idling(phase != 1 && phase != 3, phase != 2 && phase != 3);
            span = (lim > base) ? 32'(lim) - 32'(base) : 1;
            for (n = 0; n < 80; n++)
                send_random_command(span);
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = css_pkg::REG_REGION_BASE;
        i_cfg_data     = '0;
        cmd_chan.valid = 1'b0;
        cmd_chan.data  = '0;
        cfg_base       = css_pkg::RST_REGION_BASE;
        cfg_end        = css_pkg::RST_REGION_END;
        cfg_max_len    = css_pkg::RST_MAX_ENTRY;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_off[i] = '0;
            slot_len[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_commands();
        test_config_extremes();
        test_full_table_compaction();
        test_output_hold_off();
        test_random_mix();

        wait_idle();
        repeat (400) @(posedge i_clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
